>>> hdl/trs_pkg.sv
// Package for the TRS affine matrix block: payload structs, stage structs,
// fixed-point widths and the round-and-saturate helper.
// Depends on nothing; every other file in the block imports it.
package trs_pkg;

    // Field widths of the transform and of the matrix entries
    localparam int QuatW    = 16;
    localparam int TransW   = 32;
    localparam int ScaleW   = 16;
    localparam int EntryW   = 32;

    // Quaternion products are Q4.28; rotation entries need two guard bits
    localparam int ProdW    = 2 * QuatW;
    localparam int RotW     = ProdW + 2;
    // Rotation times Q8.8 scale is in units of 2^-36
    localparam int ScaledW  = RotW + ScaleW;
    // Shift from 2^-36 units down to Q16.16
    localparam int FracShift = 20;
    localparam int QuotW    = ScaledW + 1 - FracShift;

    // 1.0 in Q4.28
    localparam logic signed [RotW-1:0] OneQ28 = RotW'(64'sd1 <<< 28);

    // Saturation bounds of a Q16.16 entry
    localparam logic signed [63:0] EntryMax = 64'sd2147483647;
    localparam logic signed [63:0] EntryMin = -64'sd2147483648;

    // One input beat: quaternion, translation and scale
    typedef struct packed {
        logic signed [QuatW-1:0]  quat_w;
        logic signed [QuatW-1:0]  quat_x;
        logic signed [QuatW-1:0]  quat_y;
        logic signed [QuatW-1:0]  quat_z;
        logic signed [TransW-1:0] trans_x;
        logic signed [TransW-1:0] trans_y;
        logic signed [TransW-1:0] trans_z;
        logic signed [ScaleW-1:0] scale_x;
        logic signed [ScaleW-1:0] scale_y;
        logic signed [ScaleW-1:0] scale_z;
    } trs_xform_t;

    // One output beat: the top three rows of the affine matrix
    typedef struct packed {
        logic signed [EntryW-1:0] m_r0_c0;
        logic signed [EntryW-1:0] m_r0_c1;
        logic signed [EntryW-1:0] m_r0_c2;
        logic signed [EntryW-1:0] m_r0_c3;
        logic signed [EntryW-1:0] m_r1_c0;
        logic signed [EntryW-1:0] m_r1_c1;
        logic signed [EntryW-1:0] m_r1_c2;
        logic signed [EntryW-1:0] m_r1_c3;
        logic signed [EntryW-1:0] m_r2_c0;
        logic signed [EntryW-1:0] m_r2_c1;
        logic signed [EntryW-1:0] m_r2_c2;
        logic signed [EntryW-1:0] m_r2_c3;
    } trs_matrix_t;

    // Translation and scale ride along with the arithmetic stages
    typedef struct packed {
        logic signed [TransW-1:0] trans_x;
        logic signed [TransW-1:0] trans_y;
        logic signed [TransW-1:0] trans_z;
        logic signed [ScaleW-1:0] scale_x;
        logic signed [ScaleW-1:0] scale_y;
        logic signed [ScaleW-1:0] scale_z;
    } trs_side_t;

    // First stage result: the nine quaternion products in Q4.28
    typedef struct packed {
        logic signed [ProdW-1:0] xx;
        logic signed [ProdW-1:0] yy;
        logic signed [ProdW-1:0] zz;
        logic signed [ProdW-1:0] xy;
        logic signed [ProdW-1:0] xz;
        logic signed [ProdW-1:0] yz;
        logic signed [ProdW-1:0] wx;
        logic signed [ProdW-1:0] wy;
        logic signed [ProdW-1:0] wz;
        trs_side_t               side;
    } trs_prod_t;

    // Second stage result: the unnormalized rotation matrix in Q4.28
    typedef struct packed {
        logic signed [RotW-1:0] r00;
        logic signed [RotW-1:0] r01;
        logic signed [RotW-1:0] r02;
        logic signed [RotW-1:0] r10;
        logic signed [RotW-1:0] r11;
        logic signed [RotW-1:0] r12;
        logic signed [RotW-1:0] r20;
        logic signed [RotW-1:0] r21;
        logic signed [RotW-1:0] r22;
        trs_side_t              side;
    } trs_rot_t;

    // Rounds a 2^-36 product to Q16.16 (ties toward plus infinity) and
    // clamps it to the signed 32-bit range.
    function automatic logic signed [EntryW-1:0] round_sat(
        input logic signed [ScaledW-1:0] p
    );
        logic signed [ScaledW:0]  biased;
        logic signed [QuotW-1:0]  quot;
        logic signed [63:0]       wide;
        logic signed [EntryW-1:0] res;
        biased = (ScaledW+1)'(p) + (ScaledW+1)'(64'sd1 <<< (FracShift - 1));
        quot   = biased[ScaledW:FracShift];
        wide   = 64'(quot);
        if (wide > EntryMax) begin
            res = EntryW'(EntryMax);
        end else if (wide < EntryMin) begin
            res = EntryW'(EntryMin);
        end else begin
            res = wide[EntryW-1:0];
        end
        return res;
    endfunction

endpackage

>>> hdl/trs_quat_prod.sv
// First pipeline stage: the nine pairwise quaternion products.
// Depends on trs_pkg for the payload and stage structs.
module trs_quat_prod
    import trs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       xform_valid,
    output logic       xform_ready,
    input  trs_xform_t xform,
    output logic       prod_valid,
    input  logic       prod_ready,
    output trs_prod_t  prod
);

    logic      valid_reg;
    logic      load;
    trs_prod_t prod_reg;
    trs_prod_t prod_next;

    // The stage takes a beat when it is empty or its content moves on.
    assign load        = !valid_reg || prod_ready;
    assign xform_ready = load;

    // Products of the quaternion components, exact in Q4.28.
    always_comb
    begin
        prod_next.xx = xform.quat_x * xform.quat_x;
        prod_next.yy = xform.quat_y * xform.quat_y;
        prod_next.zz = xform.quat_z * xform.quat_z;
        prod_next.xy = xform.quat_x * xform.quat_y;
        prod_next.xz = xform.quat_x * xform.quat_z;
        prod_next.yz = xform.quat_y * xform.quat_z;
        prod_next.wx = xform.quat_w * xform.quat_x;
        prod_next.wy = xform.quat_w * xform.quat_y;
        prod_next.wz = xform.quat_w * xform.quat_z;
        prod_next.side.trans_x = xform.trans_x;
        prod_next.side.trans_y = xform.trans_y;
        prod_next.side.trans_z = xform.trans_z;
        prod_next.side.scale_x = xform.scale_x;
        prod_next.side.scale_y = xform.scale_y;
        prod_next.side.scale_z = xform.scale_z;
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= xform_valid;
        end
    end

    // Data register of the stage.
    always_ff @(posedge clk)
    begin
        if (load && xform_valid) begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = valid_reg;
    assign prod       = prod_reg;

endmodule

>>> hdl/trs_rot_build.sv
// Second pipeline stage: sums the quaternion products into the rotation matrix.
// Depends on trs_pkg for the stage structs and the Q4.28 one.
module trs_rot_build
    import trs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      prod_valid,
    output logic      prod_ready,
    input  trs_prod_t prod,
    output logic      rot_valid,
    input  logic      rot_ready,
    output trs_rot_t  rot
);

    logic     valid_reg;
    logic     load;
    trs_rot_t rot_reg;
    trs_rot_t rot_next;

    logic signed [RotW-1:0] xx;
    logic signed [RotW-1:0] yy;
    logic signed [RotW-1:0] zz;
    logic signed [RotW-1:0] xy;
    logic signed [RotW-1:0] xz;
    logic signed [RotW-1:0] yz;
    logic signed [RotW-1:0] wx;
    logic signed [RotW-1:0] wy;
    logic signed [RotW-1:0] wz;

    assign load       = !valid_reg || rot_ready;
    assign prod_ready = load;

    // Standard quaternion rotation matrix, without normalization.
    always_comb
    begin
        xx = RotW'(prod.xx);
        yy = RotW'(prod.yy);
        zz = RotW'(prod.zz);
        xy = RotW'(prod.xy);
        xz = RotW'(prod.xz);
        yz = RotW'(prod.yz);
        wx = RotW'(prod.wx);
        wy = RotW'(prod.wy);
        wz = RotW'(prod.wz);
        rot_next.r00  = OneQ28 - ((yy + zz) <<< 1);
        rot_next.r01  = (xy - wz) <<< 1;
        rot_next.r02  = (xz + wy) <<< 1;
        rot_next.r10  = (xy + wz) <<< 1;
        rot_next.r11  = OneQ28 - ((xx + zz) <<< 1);
        rot_next.r12  = (yz - wx) <<< 1;
        rot_next.r20  = (xz - wy) <<< 1;
        rot_next.r21  = (yz + wx) <<< 1;
        rot_next.r22  = OneQ28 - ((xx + yy) <<< 1);
        rot_next.side = prod.side;
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= prod_valid;
        end
    end

    // Data register of the stage.
    always_ff @(posedge clk)
    begin
        if (load && prod_valid) begin
            rot_reg <= rot_next;
        end
    end

    assign rot_valid = valid_reg;
    assign rot       = rot_reg;

endmodule

>>> hdl/trs_scale_round.sv
// Third and fourth pipeline stages: column scaling multiplies, then rounding
// to Q16.16 with saturation into the output register. Depends on trs_pkg.
module trs_scale_round
    import trs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rot_valid,
    output logic        rot_ready,
    input  trs_rot_t    rot,
    output logic        mat_valid,
    input  logic        mat_ready,
    output trs_matrix_t mat
);

    logic        mul_valid_reg;
    logic        out_valid_reg;
    logic        mul_load;
    logic        out_load;
    trs_matrix_t mat_reg;
    trs_matrix_t mat_next;
    trs_side_t   side_reg;

    logic signed [ScaledW-1:0] scaled_reg [9];
    logic signed [ScaledW-1:0] scaled_next [9];

    assign out_load  = !out_valid_reg || mat_ready;
    assign mul_load  = !mul_valid_reg || out_load;
    assign rot_ready = mul_load;

    // Column j of the rotation matrix times scale j, exact.
    always_comb
    begin
        scaled_next[0] = rot.r00 * rot.side.scale_x;
        scaled_next[1] = rot.r01 * rot.side.scale_y;
        scaled_next[2] = rot.r02 * rot.side.scale_z;
        scaled_next[3] = rot.r10 * rot.side.scale_x;
        scaled_next[4] = rot.r11 * rot.side.scale_y;
        scaled_next[5] = rot.r12 * rot.side.scale_z;
        scaled_next[6] = rot.r20 * rot.side.scale_x;
        scaled_next[7] = rot.r21 * rot.side.scale_y;
        scaled_next[8] = rot.r22 * rot.side.scale_z;
    end

    // Rounding, saturation and the translation column.
    always_comb
    begin
        mat_next.m_r0_c0 = round_sat(scaled_reg[0]);
        mat_next.m_r0_c1 = round_sat(scaled_reg[1]);
        mat_next.m_r0_c2 = round_sat(scaled_reg[2]);
        mat_next.m_r0_c3 = side_reg.trans_x;
        mat_next.m_r1_c0 = round_sat(scaled_reg[3]);
        mat_next.m_r1_c1 = round_sat(scaled_reg[4]);
        mat_next.m_r1_c2 = round_sat(scaled_reg[5]);
        mat_next.m_r1_c3 = side_reg.trans_y;
        mat_next.m_r2_c0 = round_sat(scaled_reg[6]);
        mat_next.m_r2_c1 = round_sat(scaled_reg[7]);
        mat_next.m_r2_c2 = round_sat(scaled_reg[8]);
        mat_next.m_r2_c3 = side_reg.trans_z;
    end

    // Valid bits of the multiply stage and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (mul_load) begin
                mul_valid_reg <= rot_valid;
            end
            if (out_load) begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    // Data registers of both stages.
    always_ff @(posedge clk)
    begin
        if (mul_load && rot_valid) begin
            scaled_reg <= scaled_next;
            side_reg   <= rot.side;
        end
        if (out_load && mul_valid_reg) begin
            mat_reg <= mat_next;
        end
    end

    assign mat_valid = out_valid_reg;
    assign mat       = mat_reg;

endmodule

>>> hdl/trs_affine_matrix_compose.sv
// TRS affine matrix compose: quaternion, translation and scale in, 3x4 matrix out.
// An accepted transform beat reaches its matrix beat through four register stages,
// set by the product, sum, scale-multiply and round steps. Throughput is one beat
// per cycle while mat_ready is high, and a stall holds every stage that holds a beat.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data is unreset.
// Depends on trs_pkg, trs_quat_prod, trs_rot_build and trs_scale_round.
module trs_affine_matrix_compose
    import trs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        xform_valid,
    output logic        xform_ready,
    input  trs_xform_t  xform,
    output logic        mat_valid,
    input  logic        mat_ready,
    output trs_matrix_t mat
);

    logic      prod_valid;
    logic      prod_ready;
    trs_prod_t prod;
    logic      rot_valid;
    logic      rot_ready;
    trs_rot_t  rot;

    // Stage one: quaternion products.
    trs_quat_prod u_quat_prod (
        .clk         (clk),
        .rst_n       (rst_n),
        .xform_valid (xform_valid),
        .xform_ready (xform_ready),
        .xform       (xform),
        .prod_valid  (prod_valid),
        .prod_ready  (prod_ready),
        .prod        (prod)
    );

    // Stage two: rotation matrix.
    trs_rot_build u_rot_build (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .rot_valid  (rot_valid),
        .rot_ready  (rot_ready),
        .rot        (rot)
    );

    // Stages three and four: scaling, rounding and the output register.
    trs_scale_round u_scale_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .rot_valid (rot_valid),
        .rot_ready (rot_ready),
        .rot       (rot),
        .mat_valid (mat_valid),
        .mat_ready (mat_ready),
        .mat       (mat)
    );

endmodule

>>> hdl/trs_checker.sv
// Port-level checks for the TRS affine matrix block, bound to its top level.
// Depends on trs_pkg for the payload structs.
module trs_checker
    import trs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        xform_valid,
    input logic        xform_ready,
    input trs_xform_t  xform,
    input logic        mat_valid,
    input logic        mat_ready,
    input trs_matrix_t mat
);

    // A taken output beat always frees room for a new input beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        mat_ready |-> xform_ready)
        else $error("input stalled while the output side was ready");

    // With the output side ready while the beat moves through the stages, its matrix beat
    // arrives with the x and z translation entries passed through unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (xform_valid && xform_ready) ##1 mat_ready ##1 mat_ready ##1 mat_ready
        |=> mat_valid && (mat.m_r0_c3 == $past(xform.trans_x, 4))
            && (mat.m_r2_c3 == $past(xform.trans_z, 4)))
        else $error("matrix beat late or translation column corrupted");

    // An offered matrix beat stays offered until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mat_valid && !mat_ready) |=> mat_valid)
        else $error("matrix beat withdrawn before it was taken");

    // A stalled matrix beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mat_valid && !mat_ready) |=> $stable(mat))
        else $error("matrix payload changed during a stall");

endmodule

bind trs_affine_matrix_compose trs_checker u_trs_checker (.*);

>>> dv/tb_trs_affine_matrix_compose.sv
// Testbench for trs_affine_matrix_compose: drives transform beats and checks every
// matrix beat against a local fixed-point model of translation * rotation * scale.
// Depends on trs_pkg and the trs_affine_matrix_compose RTL.
module tb_trs_affine_matrix_compose;
    import trs_pkg::*;

    localparam int      IdlePct    = 15;
    localparam int      StallLimit = 1000;
    localparam int      FlushCycles = 8;
    localparam int      NumEntries = 12;
    localparam longint  UnitRot    = 64'sd1 <<< 28;
    localparam longint  HalfLsb    = 64'sd1 <<< 19;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        xform_valid = 1'b0;
    logic        xform_ready;
    trs_xform_t  xform = '0;
    logic        mat_valid;
    logic        mat_ready = 1'b0;
    trs_matrix_t mat;

    // Matrices predicted for accepted transforms, oldest first
    trs_matrix_t expected_mats[$];
    int          error_count = 0;
    int          xforms_sent = 0;
    int          mats_checked = 0;
    int          stall_cycles = 0;
    int          steady_beats = 0;
    bit          steady_flow = 1'b0;

    const string entry_names[NumEntries] = '{
        "m_r0_c0", "m_r0_c1", "m_r0_c2", "m_r0_c3",
        "m_r1_c0", "m_r1_c1", "m_r1_c2", "m_r1_c3",
        "m_r2_c0", "m_r2_c1", "m_r2_c2", "m_r2_c3"
    };

    trs_affine_matrix_compose i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .xform_valid (xform_valid),
        .xform_ready (xform_ready),
        .xform       (xform),
        .mat_valid   (mat_valid),
        .mat_ready   (mat_ready),
        .mat         (mat)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Multiplies a Q4.28 rotation entry by a Q8.8 scale, rounds half up to
    // Q16.16 and clamps to the 32-bit range.
    function automatic logic [31:0] scale_and_round(longint rot, longint scl);
        longint prod;
        longint q;
        prod = rot * scl;
        q = (prod + HalfLsb) >>> 20;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    // Builds the expected 3x4 affine matrix for one transform.
    function automatic trs_matrix_t compose_affine(trs_xform_t t);
        longint w, x, y, z, sx, sy, sz;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        trs_matrix_t m;
        w  = longint'(t.quat_w);
        x  = longint'(t.quat_x);
        y  = longint'(t.quat_y);
        z  = longint'(t.quat_z);
        sx = longint'(t.scale_x);
        sy = longint'(t.scale_y);
        sz = longint'(t.scale_z);
        xx = x * x; yy = y * y; zz = z * z;
        xy = x * y; xz = x * z; yz = y * z;
        wx = w * x; wy = w * y; wz = w * z;
        m.m_r0_c0 = scale_and_round(UnitRot - 2 * (yy + zz), sx);
        m.m_r0_c1 = scale_and_round(2 * (xy - wz), sy);
        m.m_r0_c2 = scale_and_round(2 * (xz + wy), sz);
        m.m_r0_c3 = t.trans_x;
        m.m_r1_c0 = scale_and_round(2 * (xy + wz), sx);
        m.m_r1_c1 = scale_and_round(UnitRot - 2 * (xx + zz), sy);
        m.m_r1_c2 = scale_and_round(2 * (yz - wx), sz);
        m.m_r1_c3 = t.trans_y;
        m.m_r2_c0 = scale_and_round(2 * (xz - wy), sx);
        m.m_r2_c1 = scale_and_round(2 * (yz + wx), sy);
        m.m_r2_c2 = scale_and_round(UnitRot - 2 * (xx + yy), sz);
        m.m_r2_c3 = t.trans_z;
        return m;
    endfunction

    // Compares one matrix beat with the oldest prediction, entry by entry.
    task automatic check_matrix(trs_matrix_t got);
        trs_matrix_t want;
        logic [31:0] want_e;
        logic [31:0] got_e;
        if (expected_mats.size() == 0) begin
            $error("matrix beat with no transform pending: %h", got);
            error_count++;
            return;
        end
        want = expected_mats.pop_front();
        for (int k = 0; k < NumEntries; k++) begin
            want_e = want[(NumEntries - 1 - k) * 32 +: 32];
            got_e  = got[(NumEntries - 1 - k) * 32 +: 32];
            if (got_e !== want_e) begin
                $error("%s: expected %0d (%h), got %0d (%h)", entry_names[k],
                       $signed(want_e), want_e, $signed(got_e), got_e);
                error_count++;
            end
        end
        mats_checked++;
    endtask

    // Output side: random backpressure, prediction on input beats, checking
    // on output beats, and a watchdog on cycles with no beat at all.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (xform_valid && xform_ready) begin
                expected_mats.push_back(compose_affine(xform));
                xforms_sent++;
                if (steady_flow)
                    steady_beats++;
            end
            if (mat_valid && mat_ready)
                check_matrix(mat);
            if ((xform_valid && xform_ready) || (mat_valid && mat_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= StallLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
        mat_ready <= steady_flow || ($urandom_range(0, 99) >= IdlePct);
    end

    // Sends one transform beat, with an optional random gap before it.
    task automatic send_xform(trs_xform_t t);
        while (!steady_flow && $urandom_range(0, 99) < IdlePct) begin
            xform_valid <= 1'b0;
            @(posedge clk);
        end
        xform       <= t;
        xform_valid <= 1'b1;
        do
            @(posedge clk);
        while (!xform_ready);
    endtask

    // Favors the extremes and small values of a 16-bit signed field.
    function automatic logic [15:0] pick_short();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick_long();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic trs_xform_t random_xform();
        trs_xform_t t;
        t.quat_w  = pick_short();
        t.quat_x  = pick_short();
        t.quat_y  = pick_short();
        t.quat_z  = pick_short();
        t.trans_x = pick_long();
        t.trans_y = pick_long();
        t.trans_z = pick_long();
        t.scale_x = pick_short();
        t.scale_y = pick_short();
        t.scale_z = pick_short();
        return t;
    endfunction

    // Identity rotation and unit scale: translation passes straight through.
    task automatic test_translation_passthrough();
        send_xform('{16384, 0, 0, 0, 0, 0, 0, 256, 256, 256});
        send_xform('{16384, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     256, 256, 256});
        send_xform('{16384, 0, 0, 0, 32'h5555_5555, 32'hAAAA_AAAA, 1, 256, 256, 256});
    endtask

    // Zero, maximal and unnormalized quaternions, plus scale extremes.
    task automatic test_quaternion_corners();
        send_xform('{0, 0, 0, 0, 7, 8, 9, 256, 16'hFF00, 16'h7FFF});
        send_xform('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0,
                     16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_xform('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0,
                     16'h7FFF, 16'h8000, 16'h7FFF});
        send_xform('{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1, 2, 3,
                     16'h8000, 16'h8000, 16'h8000});
        send_xform('{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1, 2, 3,
                     16'h8000, 16'h7FFF, 16'h8000});
        send_xform('{16'h7FFF, 0, 0, 0, 0, 0, 0, 256, 256, 256});
        send_xform('{16384, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_xform('{16384, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1, 16'hFFFF});
    endtask

    // Quarter and half turns about each axis and a turn about the diagonal; the quarter
    // turns exercise rounding of entries that are not exact in Q16.16.
    task automatic test_axis_rotations();
        send_xform('{11585, 11585, 0, 0, 0, 0, 0, 256, 256, 256});
        send_xform('{11585, 0, 11585, 0, 0, 0, 0, 256, 512, 16'hFF00});
        send_xform('{11585, 0, 0, 11585, 0, 0, 0, 128, 256, 384});
        send_xform('{0, 16384, 0, 0, 0, 0, 0, 256, 256, 256});
        send_xform('{0, 0, 16384, 0, 0, 0, 0, 256, 256, 256});
        send_xform('{0, 0, 0, 16384, 0, 0, 0, 256, 256, 256});
        send_xform('{8192, 8192, 8192, 8192, 5, 6, 7, 3, 16'hFFFD, 1});
    endtask

    // Random transforms with gaps and backpressure on both sides.
    task automatic test_random_with_idling(int count);
        steady_flow = 1'b0;
        repeat (count) send_xform(random_xform());
    endtask

    // Random transforms back to back with the output always ready.
    task automatic test_back_to_back(int count);
        steady_flow = 1'b1;
        repeat (count) send_xform(random_xform());
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_translation_passthrough();
        test_quaternion_corners();
        test_axis_rotations();
        test_random_with_idling(700);
        test_back_to_back(400);
        test_random_with_idling(300);

        xform_valid <= 1'b0;
        while (expected_mats.size() != 0)
            @(posedge clk);
        repeat (FlushCycles) @(posedge clk);

        $display("tb: %0d transforms sent, %0d matrices checked, %0d beats with no idling",
                 xforms_sent, mats_checked, steady_beats);
        $display("tb: directed corners, axis turns and random transforms with stalls");
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
